// ===== rtl/boel_pkg.sv =====
// shared types and constants for the bounded ordered list engine
// no dependencies; imported by the top level and boel_map

package boel_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int VAL_W  = 32;
   localparam int POS_W  = 8;
   localparam int TYPE_W = 3;
   localparam int STAT_W = 2;

   localparam int REQ_DATA_W = ((VAL_W + POS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INS_FRONT = 3'd0,
      REQ_INS_BACK  = 3'd1,
      REQ_INS_POS   = 3'd2,
      REQ_DEL_FRONT = 3'd3,
      REQ_DEL_BACK  = 3'd4,
      REQ_READ_OUT  = 3'd5
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MAP_NONE,
      MAP_INSERT,
      MAP_DEL_FRONT
   } map_op_type;

   typedef struct packed {
      map_op_type          op;
      logic [IDX_W-1:0]    idx;
      logic [CNT_W-1:0]    count;
   } map_cmd_type;

endpackage

// ===== rtl/bounded_ordered_list_engine.sv =====
// top level of the bounded ordered list engine; depends on boel_pkg, boel_map, boel_ram
// a status result is registered at the edge that takes the request, but a non-empty
// read-out streams count elements instead and takes no request until the last is out,
// one per cycle unless stalled by rsp_tready, via the ram read port and output register
// reset: synchronous, clears the count, output valid and the order map to identity;
// ram contents stay undefined until written

module bounded_ordered_list_engine
   import boel_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // item_value, position
   input  logic [TYPE_W-1:0]     req_tuser,  // req_type
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // element_value, element_count, zero pad
   output logic [STAT_W-1:0]     rsp_tuser,  // status
   output logic                  rsp_tlast   // is_last
);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_fire;
   logic                out_free;
   logic                full;
   logic                empty;
   logic                rd_last;
   req_code_type        req_code;
   logic [VAL_W-1:0]    item_value;
   logic [POS_W-1:0]    position;
   logic [POS_W:0]      pos_limit;
   logic [IDX_W-1:0]    ins_idx;
   map_cmd_type         map_cmd;
   logic [IDX_W-1:0]    look_idx;
   logic [IDX_W-1:0]    look_slot;
   logic [IDX_W-1:0]    free_slot;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [VAL_W-1:0]    ram_rd_data;

   assign item_value = req_tdata[VAL_W-1:0];
   assign position   = req_tdata[VAL_W+POS_W-1:VAL_W];
   assign req_code   = req_code_type'(req_tuser);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);
   assign pos_limit  = (POS_W + 1)'(count_ff) + (POS_W + 1)'(1);
   assign rd_last    = (CNT_W'(rd_idx_ff) + CNT_W'(1) == count_ff);
   assign look_idx   = (state_ff == S_READ) ? IDX_W'(rd_idx_ff + IDX_W'(1)) : '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      ins_idx       = '0;
      map_cmd.op    = MAP_NONE;
      map_cmd.count = count_ff;

      case (req_code)
         REQ_INS_BACK: ins_idx = count_ff[IDX_W-1:0];
         REQ_INS_POS:  ins_idx = IDX_W'(position - POS_W'(1));
         default:      ins_idx = '0;
      endcase
      map_cmd.idx = ins_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               unique case (req_code)
                  REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_POS: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else if (req_code == REQ_INS_POS &&
                                  (position == '0 || {1'b0, position} > pos_limit)) begin
                        rsp_status_in = ST_BADPOS;
                     end else begin
                        ram_wr_en  = 1'b1;
                        map_cmd.op = MAP_INSERT;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  REQ_DEL_FRONT: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        map_cmd.op = MAP_DEL_FRONT;
                        count_in   = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_DEL_BACK: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  REQ_READ_OUT: begin
                     if (empty) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_rd_en    = 1'b1;
                        rd_idx_in    = '0;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_value_in  = ram_rd_data;
               rsp_count_in  = count_ff;
               rsp_last_in   = rd_last;
               if (rd_last) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_idx_in = IDX_W'(rd_idx_ff + IDX_W'(1));
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   boel_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cmd       (map_cmd),
      .look_idx  (look_idx),
      .look_slot (look_slot),
      .free_slot (free_slot)
   );

   boel_ram #(
      .DATA_W (VAL_W),
      .WORDS  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (free_slot),
      .wr_data (item_value),
      .rd_en   (ram_rd_en),
      .rd_addr (look_slot),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_count_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("element count above depth");

   a_no_take_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !req_tready)
      else $error("request taken during read-out");

   a_count_only_on_transfer: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("count changed without a request transfer");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (count_ff == $past(count_ff) ||
                    count_ff == $past(count_ff) + CNT_W'(1) ||
                    count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("count moved by more than one");

   a_read_keeps_ram: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_READ |-> !ram_wr_en)
      else $error("ram write during read-out");
`endif

endmodule

// ===== rtl/boel_ram.sv =====
// generic single write port, single read port synchronous ram
// registered read data; no dependencies

module boel_ram #(
   parameter int DATA_W = 32,
   parameter int WORDS  = 16,
   parameter int ADDR_W = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/boel_map.sv =====
// order map: logical position to physical ram slot, a permutation of all slots
// positions at and above the count hold the free slots; depends on boel_pkg

module boel_map
   import boel_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  map_cmd_type       cmd,
   input  logic [IDX_W-1:0]  look_idx,
   output logic [IDX_W-1:0]  look_slot,
   output logic [IDX_W-1:0]  free_slot
);

   logic [IDX_W-1:0] map_ff [DEPTH];
   logic [IDX_W-1:0] map_in [DEPTH];
   logic [IDX_W-1:0] last_idx;

   assign free_slot = map_ff[cmd.count[IDX_W-1:0]];
   assign look_slot = map_ff[look_idx];
   assign last_idx  = IDX_W'(cmd.count - CNT_W'(1));

   always_comb begin
      map_in = map_ff;
      unique case (cmd.op)
         MAP_INSERT: begin
            for (int j = 1; j < DEPTH; j++) begin
               if (IDX_W'(j) > cmd.idx && CNT_W'(j) <= cmd.count) begin
                  map_in[j] = map_ff[j-1];
               end
            end
            map_in[cmd.idx] = free_slot;
         end
         MAP_DEL_FRONT: begin
            for (int j = 0; j < DEPTH - 1; j++) begin
               if (CNT_W'(j + 1) < cmd.count) begin
                  map_in[j] = map_ff[j+1];
               end
            end
            map_in[last_idx] = map_ff[0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            map_ff[j] <= IDX_W'(j);
         end
      end else begin
         map_ff <= map_in;
      end
   end

endmodule
